// ===== hw/rtl/gpf_pkg.sv =====
// Shared types, sizes and register codes of the grid peak finder.
package gpf_pkg;

    localparam int MAX_COLUMNS  = 1024;
    localparam int MAX_ROWS     = 1024;
    localparam int SAMPLE_WIDTH = 16;

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CNT_W  = 20;
    localparam int CFG_W  = 11;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // word index of each register on the configuration port
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    localparam logic [CFG_W-1:0] COLUMNS_RESET = CFG_W'(7);
    localparam logic [CFG_W-1:0] ROWS_RESET    = CFG_W'(6);
    localparam logic [CFG_W-1:0] MIN_SIZE      = CFG_W'(3);

    // one line buffer entry: the last row's sample and the one before it
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] last;
        logic signed [SAMPLE_WIDTH-1:0] older;
    } t_line;

    // effective frame size and the frame restart strobe
    typedef struct packed {
        logic [CFG_W-1:0] cols;
        logic [CFG_W-1:0] rows;
        logic             restart;
    } t_cfg;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [CNT_W-1:0] total;
        logic             done;
    } t_result;

endpackage

// ===== hw/rtl/gpf_line_ram.sv =====
// Line buffer RAM: one write port, two registered read ports.
module gpf_line_ram
    import gpf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [COL_W-1:0] i_wr_addr,
    input  t_line            i_wr_data,
    input  logic [COL_W-1:0] i_rd_addr_a,
    input  logic [COL_W-1:0] i_rd_addr_b,
    output t_line            o_rd_data_a,
    output t_line            o_rd_data_b
);

    t_line r_mem [MAX_COLUMNS];
    t_line r_rd_a;
    t_line r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== hw/rtl/gpf_cfg.sv =====
// APB register file: column and row counts, clamped frame size, restart strobe.
module gpf_cfg
    import gpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [CFG_W-1:0] r_columns;
    logic [CFG_W-1:0] r_rows;
    logic [CFG_W-1:0] n_columns;
    logic [CFG_W-1:0] n_rows;
    logic             wr_stb;
    logic             reg_idx;

    // byte lanes within a word are ignored
    assign reg_idx = paddr[ADDR_W-1];
    assign pready  = 1'b1;
    assign wr_stb  = psel && penable && pwrite && pready;

    always_comb begin
        n_columns = r_columns;
        n_rows    = r_rows;
        if (wr_stb) begin
            case (reg_idx)
                REG_COLUMNS: n_columns = pwdata[CFG_W-1:0];
                REG_ROWS:    n_rows    = pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= COLUMNS_RESET;
            r_rows    <= ROWS_RESET;
        end else begin
            r_columns <= n_columns;
            r_rows    <= n_rows;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COLUMNS: prdata = DATA_W'(r_columns);
            REG_ROWS:    prdata = DATA_W'(r_rows);
            default:     prdata = '0;
        endcase
    end

    // clamp to the sizes the line buffer supports
    always_comb begin
        if (r_columns < MIN_SIZE) begin
            o_cfg.cols = MIN_SIZE;
        end else if (r_columns > CFG_W'(MAX_COLUMNS)) begin
            o_cfg.cols = CFG_W'(MAX_COLUMNS);
        end else begin
            o_cfg.cols = r_columns;
        end
        if (r_rows < MIN_SIZE) begin
            o_cfg.rows = MIN_SIZE;
        end else if (r_rows > CFG_W'(MAX_ROWS)) begin
            o_cfg.rows = CFG_W'(MAX_ROWS);
        end else begin
            o_cfg.rows = r_rows;
        end
        o_cfg.restart = wr_stb;
    end

endmodule

// ===== hw/rtl/gpf_out_buf.sv =====
// Two-word result buffer: output register plus skid register.
module gpf_out_buf
    import gpf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_result o_data,
    output logic    o_full
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    n_out_valid;
    logic    n_skid_valid;
    t_result n_out;
    t_result n_skid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || i_out_ready) begin
            // refill the output register, skid first
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_data;
                n_out_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_data      = r_out;
    assign o_full      = r_skid_valid;

endmodule

// ===== hw/rtl/grid_peak_finder.sv =====
// Top level of the grid peak finder: position counters, peak test, RAM and buffer.
//
//  channel   direction  handshake                   word
//  --------  ---------  --------------------------  ---------------------------------
//  sample    in         i_in_valid / o_in_ready     i_elevation
//  result    out        o_out_valid / i_out_ready   o_peak_row, o_peak_column,
//                                                   o_peak_total, o_frame_done
//  config    in         APB psel/penable/pwrite     columns at 0x0, rows at 0x4
//
// One sample per cycle is accepted while o_in_ready is high. The line RAM is
// read at the next sample's column and the column after it in the cycle before
// that sample arrives, so the peak test is made in the cycle the sample is
// accepted. Reset is synchronous and active low; it clears the counters and the
// result buffer, and the line RAM needs no clearing since a frame reads only
// rows it wrote itself. A stalled result consumer fills the two-word result
// buffer, and o_in_ready drops only while both words are held.
module grid_peak_finder
    import gpf_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample stream
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_elevation,
    // result stream
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic        [ROW_W-1:0]        o_peak_row,
    output logic        [COL_W-1:0]        o_peak_column,
    output logic        [CNT_W-1:0]        o_peak_total,
    output logic                           o_frame_done,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic        [ADDR_W-1:0]       paddr,
    input  logic        [DATA_W-1:0]       pwdata,
    output logic        [DATA_W-1:0]       prdata,
    output logic                           pready
);

    t_cfg    cfg;
    t_line   rd_a;
    t_line   rd_b;
    t_line   wr_data;
    t_result res;
    t_result out_word;
    logic    buf_full;
    logic    accept;
    logic    push;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [CNT_W-1:0] r_cnt;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [CNT_W-1:0] n_cnt;

    // previous row's sample one column to the west
    logic signed [SAMPLE_WIDTH-1:0] r_west;

    logic             last_col;
    logic             last_row;
    logic             interior;
    logic             peak;
    logic [CNT_W-1:0] cnt_inc;

    gpf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_in_ready = !buf_full;
    assign accept     = i_in_valid && o_in_ready;

    // frame position tests, in the width of the size registers
    assign last_col = (CFG_W'(r_col) + CFG_W'(1)) >= cfg.cols;
    assign last_row = (CFG_W'(r_row) + CFG_W'(1)) >= cfg.rows;
    assign interior = (r_row >= ROW_W'(2)) && (r_col != '0)
                   && ((CFG_W'(r_col) + CFG_W'(2)) <= cfg.cols);

    // rd_a holds this column, rd_b the next one; center is the last row's sample
    assign peak = interior
               && (rd_a.last > rd_a.older)
               && (rd_a.last > i_elevation)
               && (rd_a.last > r_west)
               && (rd_a.last > rd_b.last);

    assign cnt_inc = (peak && (r_cnt != COUNT_MAX)) ? r_cnt + CNT_W'(1) : r_cnt;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_cnt = r_cnt;
        if (cfg.restart) begin
            // any register write starts a new frame
            n_col = '0;
            n_row = '0;
            n_cnt = '0;
        end else if (accept) begin
            n_cnt = cnt_inc;
            if (last_col) begin
                n_col = '0;
                if (last_row) begin
                    n_row = '0;
                    n_cnt = '0;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_cnt <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_west <= rd_a.last;
        end
    end

    // shift the column entry down one row and store the new sample on top
    assign wr_data.last  = i_elevation;
    assign wr_data.older = rd_a.last;

    // read ahead at the next sample's column; outside a frame restart the column
    // being written is never one of the two read, as a row has at least three columns
    gpf_line_ram u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (accept),
        .i_wr_addr   (r_col),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (n_col),
        .i_rd_addr_b (n_col + COL_W'(1)),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    // a frame end takes the result slot; a peak never falls on the last column
    always_comb begin
        if (last_col && last_row) begin
            res.row   = '0;
            res.col   = '0;
            res.total = cnt_inc;
            res.done  = 1'b1;
        end else begin
            res.row   = r_row - ROW_W'(1);
            res.col   = r_col;
            res.total = cnt_inc;
            res.done  = 1'b0;
        end
    end

    assign push = accept && (peak || (last_col && last_row));

    gpf_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (res),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_data      (out_word),
        .o_full      (buf_full)
    );

    assign o_peak_row    = out_word.row;
    assign o_peak_column = out_word.col;
    assign o_peak_total  = out_word.total;
    assign o_frame_done  = out_word.done;

    // a full skid register implies a held output word
    a_full_implies_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    // peak results always carry a nonzero running count
    a_peak_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_done) |-> (o_peak_total != '0))
        else $error("peak result with zero count");

    // the interior test never fires on the last column of a row
    a_peak_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && peak) |-> !last_col)
        else $error("peak flagged on the last column");

    // the column advances by one within a row
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !cfg.restart && !last_col) |=> (r_col == $past(r_col) + COL_W'(1)))
        else $error("column position skipped");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the grid peak finder: directed table, random frames, predictor.
`timescale 1ns / 1ps

module testbench;
    import gpf_pkg::*;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;

    // how the random frames draw their samples
    typedef enum int {MIX_FULL, MIX_TIES, MIX_EXTREMES} t_mix;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct {
        t_sample elevation;
        bit      typed;
        bit      has_result;
        t_result want;
    } t_row;

    localparam t_sample LO = 16'sh8000;
    localparam t_sample HI = 16'sh7fff;
    localparam t_sample NEG1 = -16'sd1;
    localparam t_sample ZERO = 16'sd0;
    localparam t_result NO_RESULT = '0;
    localparam int DIRECTED_ROWS = 27;
    localparam int RANDOM_ITEMS = 1300;
    localparam int EXTREME_ITEMS = 60;
    localparam int GAP_MAX = 12;
    // results pass through a registered buffer, and the buffer holds two words
    localparam int SETTLE_CYCLES = 4;

    // three 3x3 frames: a lone peak at full swing, a tie with the north
    // neighbour, and a mixed-sign frame left to the predictor
    t_row directed_rows [0:DIRECTED_ROWS-1] = '{
        '{LO, 1'b1, 1'b0, NO_RESULT},
        '{LO, 1'b1, 1'b0, NO_RESULT},
        '{LO, 1'b1, 1'b0, NO_RESULT},
        '{LO, 1'b1, 1'b0, NO_RESULT},
        '{HI, 1'b1, 1'b0, NO_RESULT},
        '{LO, 1'b1, 1'b0, NO_RESULT},
        '{LO, 1'b1, 1'b0, NO_RESULT},
        '{LO, 1'b1, 1'b1, '{10'd1, 10'd1, 20'd1, 1'b0}},
        '{LO, 1'b1, 1'b1, '{10'd0, 10'd0, 20'd1, 1'b1}},
        '{NEG1, 1'b1, 1'b0, NO_RESULT},
        '{ZERO, 1'b1, 1'b0, NO_RESULT},
        '{NEG1, 1'b1, 1'b0, NO_RESULT},
        '{NEG1, 1'b1, 1'b0, NO_RESULT},
        '{ZERO, 1'b1, 1'b0, NO_RESULT},
        '{NEG1, 1'b1, 1'b0, NO_RESULT},
        '{NEG1, 1'b1, 1'b0, NO_RESULT},
        '{NEG1, 1'b1, 1'b0, NO_RESULT},
        '{NEG1, 1'b1, 1'b1, '{10'd0, 10'd0, 20'd0, 1'b1}},
        '{16'sh5555, 1'b0, 1'b0, NO_RESULT},
        '{16'shaaaa, 1'b0, 1'b0, NO_RESULT},
        '{16'sh0001, 1'b0, 1'b0, NO_RESULT},
        '{16'sh1234, 1'b0, 1'b0, NO_RESULT},
        '{16'sh7ffe, 1'b0, 1'b0, NO_RESULT},
        '{16'sh8001, 1'b0, 1'b0, NO_RESULT},
        '{16'sh00ff, 1'b0, 1'b0, NO_RESULT},
        '{16'shff00, 1'b0, 1'b0, NO_RESULT},
        '{16'sh0000, 1'b0, 1'b0, NO_RESULT}
    };

    // clock, reset and every block input, known from time zero
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    t_sample           elevation = '0;
    logic              out_ready = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;

    logic              o_in_ready;
    logic              o_out_valid;
    logic [ROW_W-1:0]  o_peak_row;
    logic [COL_W-1:0]  o_peak_column;
    logic [CNT_W-1:0]  o_peak_total;
    logic              o_frame_done;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // predictor state: raw register values, two line buffers, position, count
    logic [CFG_W-1:0]  cols_reg = COLUMNS_RESET;
    logic [CFG_W-1:0]  rows_reg = ROWS_RESET;
    t_sample           line_mem [2][MAX_COLUMNS];
    int unsigned       row_at = 0;
    int unsigned       col_at = 0;
    logic [CNT_W-1:0]  peaks_so_far = '0;

    t_result           peaks_expected [$];
    t_result           oldest_peak;
    int                failures = 0;
    bit                sender_burst = 1'b0;
    bit                receiver_burst = 1'b0;

    grid_peak_finder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_elevation   (elevation),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_peak_row    (o_peak_row),
        .o_peak_column (o_peak_column),
        .o_peak_total  (o_peak_total),
        .o_frame_done  (o_frame_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    // hard stop in case a handshake never completes
    initial begin
        #20_000_000;
        $display("grid_peak_finder test failed");
        $finish;
    end

    // clamp a register value to the sizes the block supports
    function automatic int unsigned clamp_size(logic [CFG_W-1:0] raw, int unsigned hi);
        if (raw < MIN_SIZE) return MIN_SIZE;
        if (raw > hi) return hi;
        return raw;
    endfunction

    function automatic int unsigned frame_columns();
        return clamp_size(cols_reg, MAX_COLUMNS);
    endfunction

    function automatic int unsigned frame_rows();
        return clamp_size(rows_reg, MAX_ROWS);
    endfunction

    // advance the grid by one sample; return 1 with the result it causes
    function automatic bit predict_peak(input t_sample s, output t_result res);
        int unsigned cols;
        int unsigned rows;
        int unsigned r;
        int unsigned c;
        t_sample     centre;
        bit          got;
        cols = frame_columns();
        rows = frame_rows();
        r = row_at;
        c = col_at;
        got = 1'b0;
        res = '0;
        // test the cell one row up once its south neighbour is here
        if (r >= 2 && c >= 1 && c + 2 <= cols) begin
            centre = line_mem[(r - 1) & 1][c];
            if (centre > line_mem[r & 1][c] && centre > s &&
                centre > line_mem[(r - 1) & 1][c - 1] &&
                centre > line_mem[(r - 1) & 1][c + 1]) begin
                if (peaks_so_far != COUNT_MAX) peaks_so_far = peaks_so_far + 1'b1;
                res.row   = ROW_W'(r - 1);
                res.col   = COL_W'(c);
                res.total = peaks_so_far;
                res.done  = 1'b0;
                got = 1'b1;
            end
        end
        line_mem[r & 1][c] = s;
        if (c + 1 >= cols) begin
            col_at = 0;
            if (r + 1 >= rows) begin
                // last sample of the frame: report the total and start over
                res.row   = '0;
                res.col   = '0;
                res.total = peaks_so_far;
                res.done  = 1'b1;
                got = 1'b1;
                row_at = 0;
                peaks_so_far = '0;
            end else begin
                row_at = r + 1;
            end
        end else begin
            col_at = c + 1;
        end
        return got;
    endfunction

    function automatic t_sample draw_sample(t_mix mix);
        case (mix)
            MIX_TIES: begin
                return t_sample'(int'($urandom_range(0, 3)) - 2);
            end
            MIX_EXTREMES: begin
                case ($urandom_range(0, 3))
                    0: return LO;
                    1: return HI;
                    2: return ZERO;
                    default: return NEG1;
                endcase
            end
            default: begin
                return t_sample'($urandom);
            end
        endcase
    endfunction

    // present one word on the sample channel and hold it until it is taken
    task automatic send_sample(input t_sample s);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, GAP_MAX);
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid  <= 1'b1;
        elevation <= s;
        do @(posedge i_clk); while (!(in_valid && o_in_ready));
    endtask

    task automatic feed_sample(input t_sample s);
        t_result res;
        send_sample(s);
        if (predict_peak(s, res)) peaks_expected.push_back(res);
    endtask

    // drop valid and hold off until every expected word has come back
    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (peaks_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endtask

    // APB write: setup cycle, then access cycle; junk above the 11 register bits
    task automatic write_register(input logic which, input logic [CFG_W-1:0] size);
        logic [DATA_W-1:0] word;
        word = $urandom;
        word[CFG_W-1:0] = size;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // any register write restarts the frame; the line buffers stay
        if (which == REG_COLUMNS) cols_reg = size;
        else rows_reg = size;
        row_at = 0;
        col_at = 0;
        peaks_so_far = '0;
        @(negedge i_clk);
        // read back through the address still on the bus
        report_field("prdata", int'(size), int'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // pick a frame size that is mostly small, sometimes clamped from below
    function automatic logic [CFG_W-1:0] small_size();
        if ($urandom_range(0, 7) == 0) return CFG_W'($urandom_range(0, 2));
        return CFG_W'($urandom_range(3, 12));
    endfunction

    // result consumer: stall a random number of cycles ahead of every word,
    // with stretches of no stalls in between
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) receiver_burst = !receiver_burst;
            stall = receiver_burst ? 0 : $urandom_range(0, GAP_MAX);
            repeat (stall) begin
                @(negedge i_clk);
                out_ready <= 1'b0;
            end
            @(negedge i_clk);
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && out_ready));
        end
    end

    // compare every accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (peaks_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual row %0d col %0d total %0d done %0b",
                         $time, o_peak_row, o_peak_column, o_peak_total, o_frame_done);
                failures++;
            end else begin
                oldest_peak = peaks_expected.pop_front();
                report_field("peak_row", oldest_peak.row, o_peak_row);
                report_field("peak_column", oldest_peak.col, o_peak_column);
                report_field("peak_total", oldest_peak.total, o_peak_total);
                report_field("frame_done", oldest_peak.done, o_frame_done);
            end
        end
    end

    // stimulus
    initial begin
        t_result     res;
        bit          got;
        int          random_fed;
        int          phase;
        int          frames;
        int unsigned frame_len;
        t_mix        mix;

        random_fed = 0;
        phase = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one frame at the reset size of 7 x 6
        frame_len = frame_columns() * frame_rows();
        for (int unsigned k = 0; k < frame_len; k++) feed_sample(draw_sample(MIX_FULL));
        settle();

        // directed table on the smallest grid
        write_register(REG_COLUMNS, MIN_SIZE);
        write_register(REG_ROWS, MIN_SIZE);
        foreach (directed_rows[k]) begin
            send_sample(directed_rows[k].elevation);
            got = predict_peak(directed_rows[k].elevation, res);
            if (directed_rows[k].typed) begin
                got = directed_rows[k].has_result;
                res = directed_rows[k].want;
            end
            if (got) peaks_expected.push_back(res);
        end
        settle();

        // random phases: new sizes, a few whole frames, now and then a cut-off
        // frame that the next register write restarts
        while (random_fed < RANDOM_ITEMS) begin
            if (phase == 3) begin
                // widest rows, register all ones and all zeros
                write_register(REG_COLUMNS, {CFG_W{1'b1}});
                write_register(REG_ROWS, '0);
            end else if (phase == 7) begin
                // tallest frame on the narrowest rows
                write_register(REG_ROWS, CFG_W'(MAX_ROWS));
                write_register(REG_COLUMNS, CFG_W'(1));
            end else if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 0) write_register(REG_COLUMNS, small_size());
                else write_register(REG_ROWS, small_size());
            end else begin
                write_register(REG_COLUMNS, small_size());
                write_register(REG_ROWS, small_size());
            end
            sender_burst = ($urandom_range(0, 3) == 0);
            frame_len = frame_columns() * frame_rows();
            // only start the widest and the tallest frame; the next write cuts it off
            if (phase == 3 || phase == 7) frame_len = EXTREME_ITEMS;
            frames = (phase == 3 || phase == 7) ? 1 : $urandom_range(1, 3);
            repeat (frames) begin
                mix = ($urandom_range(0, 3) < 2) ? MIX_FULL : t_mix'($urandom_range(1, 2));
                for (int unsigned k = 0; k < frame_len; k++) begin
                    feed_sample(draw_sample(mix));
                    random_fed++;
                    // now and then hold off mid-frame until the results drain
                    if ($urandom_range(0, 199) == 0) settle();
                end
            end
            if (phase != 3 && phase != 7 && $urandom_range(0, 2) == 0) begin
                mix = t_mix'($urandom_range(0, 2));
                repeat ($urandom_range(1, frame_len - 1)) begin
                    feed_sample(draw_sample(mix));
                    random_fed++;
                end
            end
            settle();
            phase++;
        end

        settle();
        if (failures == 0) begin
            $display("grid_peak_finder test passed");
        end else begin
            $display("grid_peak_finder test failed");
        end
        $finish;
    end

endmodule
